// ===== src/assert_macros.svh =====
// Assertion macros for the erf pipeline RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge, cons holds at the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante holds at an edge, cons holds after the delay dly
`define ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

// ===== src/erfr_pkg.sv =====
// Types, constants and helper functions of the erf pipeline.
// No dependencies; imported by every erf module.
package erfr_pkg;

    localparam int WORK_W         = 44;
    localparam int FRAC           = 40;
    localparam int HALF_W         = 22;
    localparam int PROD_W         = 88;
    localparam int HORNER_STEPS   = 6;
    localparam int SQUARINGS      = 4;
    localparam int RECIP_STEPS    = 42;
    localparam int STEPS_PER_STG  = 2;
    localparam int RECIP_STAGES   = RECIP_STEPS / STEPS_PER_STG;
    // input reg, Horner muls, divider + round, squarings, two output stages
    localparam int LATENCY = 1 + 2 * HORNER_STEPS + RECIP_STAGES + 1 + 2 * SQUARINGS + 2;

    typedef logic [WORK_W-1:0] work_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic [WORK_W-1:0]      rem;
        logic [RECIP_STEPS-1:0] quo;
    } div_t;

    localparam longint unsigned DecScale = 64'd10000000000;

    // n / 10^10 in Q40, half up
    function automatic work_t dec_to_work(longint unsigned n);
        longint unsigned t;
        longint unsigned q;
        longint unsigned r;
        t = n << 20;
        q = t / DecScale;
        r = t % DecScale;
        return WORK_W'((q << 20) + (((r << 20) + DecScale / 2) / DecScale));
    endfunction

    localparam work_t WORK_ONE = WORK_W'(64'd1 << FRAC);
    localparam work_t COEF_A1  = dec_to_work(64'd705230784);
    localparam work_t COEF_A2  = dec_to_work(64'd422820123);
    localparam work_t COEF_A3  = dec_to_work(64'd92705272);
    localparam work_t COEF_A4  = dec_to_work(64'd1520143);
    localparam work_t COEF_A5  = dec_to_work(64'd2765672);
    localparam work_t COEF_A6  = dec_to_work(64'd430638);

    // addend of each Horner step, highest degree first
    localparam work_t HORNER_ADD [HORNER_STEPS] =
        '{COEF_A5, COEF_A4, COEF_A3, COEF_A2, COEF_A1, WORK_ONE};

    // one restoring division step: shift, compare, subtract
    function automatic div_t div_step(div_t s, work_t d);
        logic [WORK_W:0] sh;
        div_t            o;
        sh = {s.rem, 1'b0};
        if (sh >= {1'b0, d})
        begin
            o.rem = WORK_W'(sh - {1'b0, d});
            o.quo = {s.quo[RECIP_STEPS-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[WORK_W-1:0];
            o.quo = {s.quo[RECIP_STEPS-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== src/erf_rational_approximation.sv =====
// Top level of the erf pipeline (rational approximation, six-step Horner).
// Depends on erfr_pkg, erfr_mul, erfr_recip and assert_macros.svh.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------
//  input    | start, busy       | x_value   (Q5.27 signed)
//  result   | done (strobe)     | erf_value (Q2.30 signed)
//
// One item is accepted every cycle; busy is held low.
// The pipeline: input register, six two-stage Horner multipliers,
// a 21-stage divider plus rounding stage, four two-stage squarings and two
// output stages. The divider sets the depth at two quotient bits a stage.
// Reset clears only the control registers; results leave on done for one cycle.
`include "assert_macros.svh"

module erf_rational_approximation #(
    parameter int IN_FRAC_BITS  = 27,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_value,
    output logic               done,
    output logic signed [31:0] erf_value
);
    import erfr_pkg::*;

    localparam logic [31:0] LIMIT    = 32'(64'd6 << IN_FRAC_BITS);
    localparam int          OUT_SH   = FRAC - OUT_FRAC_BITS;
    localparam logic [31:0] SAT_MAG  = 32'(64'd1 << OUT_FRAC_BITS);

    logic  [31:0] mag;
    ctl_t         ctl0_reg, ctl0_next;
    work_t        z0_reg, z0_next;

    ctl_t  h_ctl [HORNER_STEPS+1];
    work_t h_res [HORNER_STEPS+1];
    work_t h_z   [HORNER_STEPS+1];

    ctl_t  s_ctl [SQUARINGS+1];
    work_t s_q   [SQUARINGS+1];

    ctl_t         ctla_reg, ctlb_reg;
    work_t        m_reg, m_next;
    work_t        rounded;
    logic  [31:0] res_mag;
    logic  [31:0] erf_reg, erf_next;

    // input stage: sign, magnitude, range check
    always_comb
    begin
        mag             = x_value[31] ? (32'd0 - x_value) : x_value;
        ctl0_next.valid = start;
        ctl0_next.neg   = x_value[31];
        ctl0_next.sat   = mag > LIMIT;
        z0_next         = WORK_W'(64'(mag) << (FRAC - IN_FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg <= z0_next;
    end

    assign h_ctl[0] = ctl0_reg;
    assign h_res[0] = COEF_A6;
    assign h_z[0]   = z0_reg;

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        erfr_mul u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (h_ctl[i]),
            .in_a    (h_res[i]),
            .in_b    (h_z[i]),
            .in_add  (HORNER_ADD[i]),
            .in_z    (h_z[i]),
            .out_ctl (h_ctl[i+1]),
            .out_res (h_res[i+1]),
            .out_z   (h_z[i+1])
        );
    end

    erfr_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (h_ctl[HORNER_STEPS]),
        .in_d    (h_res[HORNER_STEPS]),
        .out_ctl (s_ctl[0]),
        .out_q   (s_q[0])
    );

    for (genvar j = 0; j < SQUARINGS; j++)
    begin : g_square
        erfr_mul u_sq (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (s_ctl[j]),
            .in_a    (s_q[j]),
            .in_b    (s_q[j]),
            .in_add  ('0),
            .in_z    (s_q[j]),
            .out_ctl (s_ctl[j+1]),
            .out_res (s_q[j+1]),
            .out_z   ()
        );
    end

    // output stage A: clamp and 1 - p
    always_comb
    begin
        if (s_q[SQUARINGS] > WORK_ONE)
        begin
            m_next = '0;
        end
        else
        begin
            m_next = WORK_ONE - s_q[SQUARINGS];
        end
    end

    // output stage B: round half up, saturate, apply sign
    always_comb
    begin
        rounded  = (m_reg + WORK_W'(64'd1 << (OUT_SH - 1))) >> OUT_SH;
        res_mag  = ctla_reg.sat ? SAT_MAG : rounded[31:0];
        erf_next = ctla_reg.neg ? (32'd0 - res_mag) : res_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctla_reg <= '0;
            ctlb_reg <= '0;
        end
        else
        begin
            ctla_reg <= s_ctl[SQUARINGS];
            ctlb_reg <= ctla_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        erf_reg <= erf_next;
    end

    assign busy      = 1'b0;
    assign done      = ctlb_reg.valid;
    assign erf_value = erf_reg;

    `ASSERT_DLY(a_item_leaves, clk, rst_n, start, LATENCY, done)
    `ASSERT_DLY(a_no_phantom, clk, rst_n, !start, LATENCY, !done)
    `ASSERT_IMPL(a_range, clk, rst_n, done, (erf_value <= $signed(SAT_MAG)) && (erf_value >= -$signed(SAT_MAG)))
    `ASSERT_IMPL(a_sign, clk, rst_n, done && (erf_value != 32'sd0), erf_value[31] == $past(x_value[31], LATENCY))

endmodule

// ===== src/erfr_mul.sv =====
// Two-stage fixed-point multiply-add: round(a*b / 2^40) + addend.
// Depends on erfr_pkg; product split into four 22x22 partial products.
module erfr_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  erfr_pkg::ctl_t in_ctl,
    input  erfr_pkg::work_t in_a,
    input  erfr_pkg::work_t in_b,
    input  erfr_pkg::work_t in_add,
    input  erfr_pkg::work_t in_z,
    output erfr_pkg::ctl_t out_ctl,
    output erfr_pkg::work_t out_res,
    output erfr_pkg::work_t out_z
);
    import erfr_pkg::*;

    logic [2*HALF_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [2*HALF_W-1:0] pp_ll_next, pp_lh_next, pp_hl_next, pp_hh_next;
    ctl_t                ctl1_reg, ctl2_reg;
    work_t               add1_reg, z1_reg, z2_reg;
    work_t               res_reg, res_next;
    logic [PROD_W-1:0]   sum;

    always_comb
    begin
        pp_ll_next = in_a[HALF_W-1:0] * in_b[HALF_W-1:0];
        pp_lh_next = in_a[HALF_W-1:0] * in_b[WORK_W-1:HALF_W];
        pp_hl_next = in_a[WORK_W-1:HALF_W] * in_b[HALF_W-1:0];
        pp_hh_next = in_a[WORK_W-1:HALF_W] * in_b[WORK_W-1:HALF_W];
    end

    always_comb
    begin
        sum = PROD_W'(pp_ll_reg)
            + (PROD_W'(pp_lh_reg) << HALF_W)
            + (PROD_W'(pp_hl_reg) << HALF_W)
            + (PROD_W'(pp_hh_reg) << (2 * HALF_W))
            + (PROD_W'(1) << (FRAC - 1));
        res_next = sum[FRAC +: WORK_W] + add1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
        pp_hh_reg <= pp_hh_next;
        add1_reg  <= in_add;
        z1_reg    <= in_z;
        res_reg   <= res_next;
        z2_reg    <= z1_reg;
    end

    assign out_ctl = ctl2_reg;
    assign out_res = res_reg;
    assign out_z   = z2_reg;

endmodule

// ===== src/erfr_recip.sv =====
// Pipelined restoring divider: round(2^80 / d), two quotient bits a stage.
// Depends on erfr_pkg; one extra stage applies the rounding.
module erfr_recip (
    input  logic            clk,
    input  logic            rst_n,
    input  erfr_pkg::ctl_t  in_ctl,
    input  erfr_pkg::work_t in_d,
    output erfr_pkg::ctl_t  out_ctl,
    output erfr_pkg::work_t out_q
);
    import erfr_pkg::*;

    ctl_t  ctl_reg [RECIP_STAGES];
    div_t  st_reg  [RECIP_STAGES];
    work_t d_reg   [RECIP_STAGES];
    ctl_t  rnd_ctl_reg;
    work_t q_reg, q_next;
    div_t  st_in;

    // start at 2^39 so the first shift gives 2^40
    always_comb
    begin
        st_in.rem = WORK_W'(64'd1 << (FRAC - 1));
        st_in.quo = '0;
    end

    for (genvar g = 0; g < RECIP_STAGES; g++)
    begin : g_stage
        ctl_t  c_prev;
        div_t  s_prev;
        work_t d_prev;
        div_t  s_next;

        if (g == 0)
        begin : g_first
            assign c_prev = in_ctl;
            assign s_prev = st_in;
            assign d_prev = in_d;
        end
        else
        begin : g_rest
            assign c_prev = ctl_reg[g-1];
            assign s_prev = st_reg[g-1];
            assign d_prev = d_reg[g-1];
        end

        always_comb
        begin
            s_next = s_prev;
            for (int k = 0; k < STEPS_PER_STG; k++)
            begin
                s_next = div_step(s_next, d_prev);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else
            begin
                ctl_reg[g] <= c_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[g] <= s_next;
            d_reg[g]  <= d_prev;
        end
    end

    // the last quotient bit is the half bit: (q + 1) >> 1 rounds half up
    always_comb
    begin
        q_next = WORK_W'((({1'b0, st_reg[RECIP_STAGES-1].quo}) + (RECIP_STEPS + 1)'(1)) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_ctl_reg <= '0;
        end
        else
        begin
            rnd_ctl_reg <= ctl_reg[RECIP_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign out_ctl = rnd_ctl_reg;
    assign out_q   = q_reg;

endmodule

// ===== tb/erf_rational_approximation_test.sv =====
// Testbench for erf_rational_approximation: directed table, then random items
// under several idle phases, each checked against a bit-exact erf predictor.
// Depends only on the erf_rational_approximation RTL.
module erf_rational_approximation_test;

    localparam int OUT_ONE     = 1 << 30;
    localparam int DRAIN_WAIT  = 60;
    localparam int WDOG_LIMIT  = 5000;
    localparam int RAND_ITEMS  = 1830;
    localparam logic [31:0] SIX_Q27 = 32'd6 << 27;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_value;
    logic               done;
    logic signed [31:0] erf_value;

    logic [31:0] erf_queue[$];
    int          fail_count;
    int          idle_cycles;
    int          idle_pct;
    int          sent_count;

    typedef struct {
        logic [31:0] x;
        bit          known;
        logic [31:0] erf;
    } stim_row_t;

    erf_rational_approximation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .x_value   (x_value),
        .done      (done),
        .erf_value (erf_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // round_half_up(a * b / 2^40)
    function automatic logic [63:0] q40_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << 39);
        return 64'(p >> 40);
    endfunction

    function automatic logic [63:0] dec_q40(longint unsigned n);
        logic [127:0] t;
        t = (128'(n) << 40) + 128'd5000000000;
        return 64'(t / 128'd10000000000);
    endfunction

    function automatic logic [31:0] erf_predict(logic [31:0] x);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] z;
        logic [63:0] acc;
        logic [63:0] q;
        logic [63:0] res;
        logic [127:0] num;
        longint unsigned coef[6];
        coef = '{705230784, 422820123, 92705272, 1520143, 2765672, 430638};
        neg = x[31];
        mag = neg ? -x : x;
        if (mag > SIX_Q27)
            res = 64'(OUT_ONE);
        else
        begin
            z = 64'(mag) << 13;
            acc = dec_q40(coef[5]);
            for (int i = 4; i >= 0; i--)
                acc = q40_mul(acc, z) + dec_q40(coef[i]);
            acc = q40_mul(acc, z) + (64'd1 << 40);
            num = (128'd1 << 80) + 128'(acc >> 1);
            q = 64'(num / 128'(acc));
            for (int i = 0; i < 4; i++)
                q = q40_mul(q, q);
            if (q > (64'd1 << 40))
                q = 64'd1 << 40;
            res = ((64'd1 << 40) - q + 64'd512) >> 10;
        end
        return neg ? -32'(res) : 32'(res);
    endfunction

    // results are sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (erf_queue.size() == 0)
            begin
                $error("erf_value: unexpected result %0d", erf_value);
                fail_count++;
            end
            else
            begin
                logic [31:0] want;
                want = erf_queue.pop_front();
                if (erf_value !== want)
                begin
                    $error("erf_value: expected %0d, actual %0d",
                           $signed(want), erf_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles without any accepted item or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_x(logic [31:0] x, bit known, logic [31:0] want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        x_value <= x;
        erf_queue.push_back(known ? want : erf_predict(x));
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (erf_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_x();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 32'($urandom_range(SIX_Q27)) * ($urandom_range(1) ? -1 : 1);
        else if (sel < 7)
            return 32'($urandom_range(1 << 24)) * ($urandom_range(1) ? -1 : 1);
        else
            return $urandom();
    endfunction

    initial
    begin
        stim_row_t table_rows[$];
        int phase_pct[4];
        phase_pct = '{0, 68, 0, 17};
        table_rows = '{
            '{32'h0000_0000, 1'b1, 32'h0},
            '{32'h7FFF_FFFF, 1'b1, 32'(OUT_ONE)},
            '{32'h8000_0000, 1'b1, -32'(OUT_ONE)},
            '{32'h8000_0001, 1'b1, -32'(OUT_ONE)},
            '{SIX_Q27 + 1,   1'b1, 32'(OUT_ONE)},
            '{-(SIX_Q27 + 1), 1'b1, -32'(OUT_ONE)},
            '{SIX_Q27,       1'b0, 32'h0},
            '{-SIX_Q27,      1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 1'b0, 32'h0},
            '{32'h0800_0000, 1'b0, 32'h0},
            '{32'hF800_0000, 1'b0, 32'h0},
            '{32'h0400_0000, 1'b0, 32'h0},
            '{32'h1000_0000, 1'b0, 32'h0},
            '{32'hEC00_0000, 1'b0, 32'h0},
            '{32'h5555_5555, 1'b0, 32'h0},
            '{32'hAAAA_AAAA, 1'b0, 32'h0}
        };
        rst_n = 1'b0;
        start = 1'b0;
        x_value = '0;
        fail_count = 0;
        idle_cycles = 0;
        idle_pct = 0;
        sent_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_x(table_rows[i].x, table_rows[i].known, table_rows[i].erf);
        drain_results();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_pct[ph];
            repeat (RAND_ITEMS / 4)
                send_x(rand_x(), 1'b0, 32'h0);
            // hold off until the pipeline is empty
            drain_results();
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && erf_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/erfr_pkg.sv
src/erfr_mul.sv
src/erfr_recip.sv
src/erf_rational_approximation.sv
tb/erf_rational_approximation_test.sv
